// ----- hw/rtl/tte_pkg.sv -----
// ----------------------------------------------------------------------------
// Token text expander package
// Shared types, codes and sizes of the token text expander.
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam int TOKEN_STORE_BYTES = 1024;
	localparam int TOKEN_COUNT       = 128;
	localparam int MAX_TOKEN_LEN     = 32;

	localparam int STORE_AW = $clog2(TOKEN_STORE_BYTES);
	localparam int POS_W    = STORE_AW + 1;
	localparam int TOK_AW   = $clog2(TOKEN_COUNT);
	localparam int IDX_W    = TOK_AW + 1;
	localparam int LEN_W    = $clog2(MAX_TOKEN_LEN + 1);
	localparam int ENTRY_W  = STORE_AW + LEN_W;
	localparam int CHR_W    = 10;

	localparam logic [7:0] XOR_MASK   = 8'hFF;
	localparam logic [7:0] TERM_CODE  = 8'h0A;
	localparam logic [7:0] TOKEN_BASE = 8'h80;
	localparam logic [CHR_W-1:0] MAX_LENGTH_RESET = CHR_W'(255);

	// Request kinds.
	localparam logic [1:0] KIND_TBL_RST   = 2'd0;
	localparam logic [1:0] KIND_TBL_BYTE  = 2'd1;
	localparam logic [1:0] KIND_MSG_FIRST = 2'd2;
	localparam logic [1:0] KIND_MSG_NEXT  = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} in_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       is_char;
		logic       message_end;
		logic       last;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FETCH,
		ST_TOK,
		ST_CHAR,
		ST_STOP
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_tok;
		logic emit_char;
		logic emit_tok;
		logic emit_stop;
	} cmd_t;

	typedef struct packed {
		logic in_msg;
		logic over;
		logic limit_hit;
		logic is_term;
		logic is_token;
		logic tok_valid;
		logic out_free;
		logic tok_last;
	} status_t;

endpackage

// ----- hw/rtl/tte_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/tte_ctrl.sv -----
// ----------------------------------------------------------------------------
// Token text expander controller
// Sequences each message byte through lookup, token fetch and result stages.
// ----------------------------------------------------------------------------
module tte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tte_pkg::status_t  st,
	output tte_pkg::cmd_t     cmd
);

	tte_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tte_pkg::ST_IDLE: begin
				if (in_valid && st.in_msg) begin
					state_d = tte_pkg::ST_DECIDE;
				end
			end
			tte_pkg::ST_DECIDE: begin
				if (st.over) begin
					state_d = tte_pkg::ST_IDLE;
				end else if (st.limit_hit || st.is_term) begin
					state_d = tte_pkg::ST_STOP;
				end else if (st.is_token) begin
					state_d = st.tok_valid ? tte_pkg::ST_FETCH : tte_pkg::ST_IDLE;
				end else begin
					state_d = tte_pkg::ST_CHAR;
				end
			end
			tte_pkg::ST_FETCH: begin
				state_d = tte_pkg::ST_TOK;
			end
			tte_pkg::ST_TOK: begin
				if (st.out_free && st.tok_last) begin
					state_d = tte_pkg::ST_IDLE;
				end
			end
			tte_pkg::ST_CHAR, tte_pkg::ST_STOP: begin
				if (st.out_free) begin
					state_d = tte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tte_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			tte_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			tte_pkg::ST_DECIDE: begin
				cmd.load_tok = 1'b1;
			end
			tte_pkg::ST_TOK: begin
				cmd.emit_tok = 1'b1;
			end
			tte_pkg::ST_CHAR: begin
				cmd.emit_char = 1'b1;
			end
			tte_pkg::ST_STOP: begin
				cmd.emit_stop = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/tte_dp.sv -----
// ----------------------------------------------------------------------------
// Token text expander datapath
// Token table loading, token stores, message counters and result register.
// ----------------------------------------------------------------------------
module tte_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tte_pkg::cmd_t                cmd,
	output tte_pkg::status_t             st,
	input  tte_pkg::in_t                 in_data,
	input  logic                         cfg_we,
	input  logic [tte_pkg::CHR_W-1:0]    cfg_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output tte_pkg::out_t                out_data
);

	logic [tte_pkg::CHR_W-1:0]       max_q;
	logic [tte_pkg::POS_W-1:0]       pos_q;
	logic [tte_pkg::IDX_W-1:0]       tidx_q;
	logic [tte_pkg::LEN_W-1:0]       run_q;
	logic                            skip_q;
	logic                            closed_q;
	logic [tte_pkg::CHR_W-1:0]       chars_q;
	logic                            over_q;
	logic [tte_pkg::TOKEN_COUNT-1:0] valid_q;
	logic [7:0]                      code_q;
	logic [tte_pkg::STORE_AW-1:0]    ptr_q;
	logic [tte_pkg::LEN_W-1:0]       cnt_q;
	logic                            out_valid_q;
	tte_pkg::out_t                   out_q;

	logic [7:0]                      dec_in;
	logic                            tbl_byte;
	logic                            tbl_close;
	logic                            store_wr;
	logic                            tok_done_wr;
	logic [tte_pkg::LEN_W-1:0]       run_inc;
	logic [tte_pkg::IDX_W-1:0]       tidx_inc;
	logic [tte_pkg::STORE_AW-1:0]    tok_start;
	logic [tte_pkg::ENTRY_W-1:0]     entry_wdata;
	logic [tte_pkg::ENTRY_W-1:0]     entry_rdata;
	logic [tte_pkg::STORE_AW-1:0]    byte_raddr;
	logic [7:0]                      byte_rdata;
	logic [tte_pkg::CHR_W:0]         chars_inc;
	logic                            end_now;
	logic                            out_free;
	logic                            emit_any;
	logic                            fire;
	tte_pkg::out_t                   res;

	assign dec_in    = in_data.value ^ tte_pkg::XOR_MASK;
	assign tbl_byte  = cmd.accept && (in_data.kind == tte_pkg::KIND_TBL_BYTE)
		&& !closed_q && !skip_q;
	assign tbl_close = (in_data.value == 8'd0)
		|| (pos_q >= tte_pkg::POS_W'(tte_pkg::TOKEN_STORE_BYTES))
		|| (tidx_q >= tte_pkg::IDX_W'(tte_pkg::TOKEN_COUNT))
		|| (run_q >= tte_pkg::LEN_W'(tte_pkg::MAX_TOKEN_LEN));
	assign store_wr    = tbl_byte && !tbl_close;
	assign tok_done_wr = store_wr && in_data.value[7];
	assign run_inc     = run_q + tte_pkg::LEN_W'(1);
	assign tidx_inc    = tidx_q + tte_pkg::IDX_W'(1);
	assign tok_start   = tte_pkg::STORE_AW'(pos_q - tte_pkg::POS_W'(run_q));
	assign entry_wdata = {tok_start, run_inc};

	assign chars_inc = {1'b0, chars_q} + (tte_pkg::CHR_W + 1)'(1);
	assign end_now   = chars_inc >= {1'b0, max_q};
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_any  = cmd.emit_char || cmd.emit_tok || cmd.emit_stop;
	assign fire      = emit_any && out_free;

	// The byte store streams: on each character taken the next address is
	// already presented so that one character follows per cycle while the result register is free.
	assign byte_raddr = (cmd.emit_tok && out_free) ? ptr_q + tte_pkg::STORE_AW'(1) : ptr_q;

	tte_ram #(
		.WIDTH(8),
		.DEPTH(tte_pkg::TOKEN_STORE_BYTES)
	) u_byte_ram (
		.clk  (clk),
		.we   (store_wr),
		.waddr(pos_q[tte_pkg::STORE_AW-1:0]),
		.wdata(in_data.value),
		.raddr(byte_raddr),
		.rdata(byte_rdata)
	);

	tte_ram #(
		.WIDTH(tte_pkg::ENTRY_W),
		.DEPTH(tte_pkg::TOKEN_COUNT)
	) u_entry_ram (
		.clk  (clk),
		.we   (tok_done_wr),
		.waddr(tidx_q[tte_pkg::TOK_AW-1:0]),
		.wdata(entry_wdata),
		.raddr(dec_in[tte_pkg::TOK_AW-1:0]),
		.rdata(entry_rdata)
	);

	always_comb begin
		st.in_msg    = (in_data.kind inside {tte_pkg::KIND_MSG_FIRST, tte_pkg::KIND_MSG_NEXT});
		st.over      = over_q;
		st.limit_hit = chars_q >= max_q;
		st.is_term   = code_q == tte_pkg::TERM_CODE;
		st.is_token  = code_q >= tte_pkg::TOKEN_BASE;
		st.tok_valid = (8'(code_q[6:0]) < 8'(tte_pkg::TOKEN_COUNT))
			&& valid_q[code_q[tte_pkg::TOK_AW-1:0]];
		st.out_free  = out_free;
		st.tok_last  = (cnt_q == tte_pkg::LEN_W'(1)) || end_now;
	end

	always_comb begin
		res = '0;
		if (cmd.emit_stop) begin
			res.message_end = 1'b1;
			res.last        = 1'b1;
		end else if (cmd.emit_char) begin
			res.char_code   = code_q[6:0];
			res.is_char     = 1'b1;
			res.message_end = end_now;
			res.last        = 1'b1;
		end else if (cmd.emit_tok) begin
			res.char_code   = byte_rdata[6:0];
			res.is_char     = 1'b1;
			res.message_end = end_now;
			res.last        = end_now || (cnt_q == tte_pkg::LEN_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= tte_pkg::MAX_LENGTH_RESET;
			pos_q       <= '0;
			tidx_q      <= '0;
			run_q       <= '0;
			skip_q      <= 1'b1;
			closed_q    <= 1'b1;
			chars_q     <= '0;
			over_q      <= 1'b1;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_data;
			end
			if (cmd.accept) begin
				case (in_data.kind)
					tte_pkg::KIND_TBL_RST: begin
						valid_q  <= '0;
						pos_q    <= '0;
						tidx_q   <= '0;
						run_q    <= '0;
						skip_q   <= 1'b1;
						closed_q <= 1'b0;
					end
					tte_pkg::KIND_TBL_BYTE: begin
						if (!closed_q) begin
							if (skip_q) begin
								skip_q <= 1'b0;
							end else if (tbl_close) begin
								closed_q <= 1'b1;
							end else begin
								pos_q <= pos_q + tte_pkg::POS_W'(1);
								run_q <= in_data.value[7] ? '0 : run_inc;
								if (in_data.value[7]) begin
									valid_q[tidx_q[tte_pkg::TOK_AW-1:0]] <= 1'b1;
									tidx_q <= tidx_inc;
									if (tidx_inc >= tte_pkg::IDX_W'(tte_pkg::TOKEN_COUNT)) begin
										closed_q <= 1'b1;
									end
								end
							end
						end
					end
					tte_pkg::KIND_MSG_FIRST: begin
						chars_q <= '0;
						over_q  <= 1'b0;
					end
					default: begin
						over_q <= over_q;
					end
				endcase
			end
			if (fire) begin
				if (cmd.emit_stop) begin
					over_q <= 1'b1;
				end else begin
					chars_q <= chars_inc[tte_pkg::CHR_W-1:0];
					if (end_now) begin
						over_q <= 1'b1;
					end
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			code_q <= dec_in;
		end
		if (cmd.load_tok) begin
			ptr_q <= entry_rdata[tte_pkg::ENTRY_W-1:tte_pkg::LEN_W];
			cnt_q <= entry_rdata[tte_pkg::LEN_W-1:0];
		end else if (fire && cmd.emit_tok) begin
			ptr_q <= ptr_q + tte_pkg::STORE_AW'(1);
			cnt_q <= cnt_q - tte_pkg::LEN_W'(1);
		end
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_emit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_char, cmd.emit_tok, cmd.emit_stop}))
		else $error("more than one result source selected");

	a_tok_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_tok |-> (cnt_q != '0))
		else $error("token expansion running with no characters left");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.message_end) |-> out_q.last)
		else $error("message end without last flag");

	a_end_over: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.message_end) |=> over_q)
		else $error("message not closed after its final result");

endmodule

// ----- hw/rtl/token_text_expander.sv -----
// ----------------------------------------------------------------------------
// Token text expander
// Loads a dictionary of tokens and expands obfuscated message bytes into
// 7-bit characters, one result per character or message end.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  in        sink       in_valid / in_stall   in_data   (tte_pkg::in_t)
//  out       source     out_valid / out_stall out_data  (tte_pkg::out_t)
//  cfg       sink       cfg_we                cfg_data  (max_length, 10 bits)
//
// A table reset or table byte request is taken while idle and gives no result.
// A message byte goes from idle through the decide state to the character or
// stop state, or back to idle when it gives no result; a token goes through
// the fetch state to the token state, where the single byte store read port
// and the one-entry result register give one character per cycle unless stalled.
// Reset clears the token valid bits at once, closes the table and ends any
// message; the stores themselves are not cleared.
// A stall on the output simply holds the sequencer in its result state.
//
module token_text_expander (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  tte_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output tte_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [tte_pkg::CHR_W-1:0] cfg_data
);

	// Commands from the controller and status back from the datapath.
	tte_pkg::cmd_t    cmd;
	tte_pkg::status_t st;

	// The controller only accepts a request while idle, so a request is
	// always finished before the next one is looked at.
	tte_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	// The datapath holds the token stores, the loading counters, the message
	// character count and the result register that decouples the output.
	tte_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ----- test/token_text_expander_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token text expander testbench
// Loads token tables of several shapes, sends obfuscated messages through the
// expander under random sender gaps and receiver stalls, and checks every
// result against a predictor that tracks the table and message state.
// ----------------------------------------------------------------------------
module token_text_expander_tb;

	import tte_pkg::*;

	// Shapes of a generated token table load.
	typedef enum int {
		TBL_PLAIN,      // a few tokens, then a zero byte or left open
		TBL_OVERLONG,   // a token that runs past the longest allowed length
		TBL_UNFINISHED, // a token cut short by a zero byte
		TBL_COUNT_FULL, // every token slot filled, the table closes by itself
		TBL_STORE_FULL  // every byte of the store filled
	} tbl_shape_e;

	// Patterns that the receiver stalls on.
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_e;

	localparam int QUIET_LIMIT   = 2000; // cycles with no handshake before giving up
	localparam int HOLD_CYCLES   = 400;  // the one long receiver hold-off
	localparam int SETTLE_CYCLES = 10;   // covers a request that is still in work
	localparam int RANDOM_REQS   = 400;

	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	in_t           in_data  = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	out_t          out_data;
	logic          cfg_we   = 1'b0;
	logic [CHR_W-1:0] cfg_data = '0;

	token_text_expander dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of the token store, the table loader and
	// the message decoder, plus the one configuration register.
	// ------------------------------------------------------------------------
	logic [7:0]         tok_mem   [TOKEN_STORE_BYTES];
	logic [STORE_AW-1:0] tok_first [TOKEN_COUNT];
	logic [LEN_W-1:0]   tok_len   [TOKEN_COUNT];
	logic [POS_W-1:0]   fill_pos;
	logic [IDX_W-1:0]   fill_tok;
	logic [LEN_W-1:0]   fill_run;
	logic               skip_next;
	logic               tbl_shut;
	logic [CHR_W-1:0]   msg_chars;
	logic               msg_done;
	logic [CHR_W-1:0]   max_len;

	out_t step_results[$];     // results of the request being predicted
	out_t expected_results[$]; // results still owed by the block
	in_t  pending_reqs[$];     // requests not yet offered to the block

	int reqs_pushed  = 0;
	int reqs_done    = 0;
	int mismatches   = 0;
	int results_seen = 0;
	int table_tokens = 0; // tokens defined by the table that was last queued

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 30)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	// Emits one character and says whether it used up the length limit.
	function automatic bit put_char(input logic [6:0] code);
		out_t o;
		msg_chars++;
		o.char_code   = code;
		o.is_char     = 1'b1;
		o.message_end = (msg_chars >= max_len);
		o.last        = 1'b0;
		step_results.push_back(o);
		if (o.message_end)
			msg_done = 1'b1;
		return o.message_end;
	endfunction

	// Works out the results of one accepted request and queues them.
	function automatic void expand_request(input in_t r);
		logic [7:0] c;
		int         idx;
		out_t       stop;
		step_results.delete();
		stop = '{char_code: 7'd0, is_char: 1'b0, message_end: 1'b1, last: 1'b0};
		case (r.kind)
			KIND_TBL_RST: begin
				foreach (tok_len[i])
					tok_len[i] = '0;
				fill_pos  = '0;
				fill_tok  = '0;
				fill_run  = '0;
				skip_next = 1'b1;
				tbl_shut  = 1'b0;
			end
			KIND_TBL_BYTE: begin
				if (tbl_shut) begin
				end else if (skip_next) begin
					skip_next = 1'b0;
				end else if (r.value == 8'h00 || fill_pos >= TOKEN_STORE_BYTES ||
						fill_tok >= TOKEN_COUNT || fill_run >= MAX_TOKEN_LEN) begin
					// The closing byte itself is not stored, and a partly loaded
					// token stays undefined.
					tbl_shut = 1'b1;
				end else begin
					tok_mem[fill_pos[STORE_AW-1:0]] = r.value;
					fill_pos++;
					fill_run++;
					if (r.value[7]) begin
						tok_first[fill_tok[TOK_AW-1:0]] = STORE_AW'(fill_pos - fill_run);
						tok_len[fill_tok[TOK_AW-1:0]]   = fill_run;
						fill_tok++;
						fill_run = '0;
						if (fill_tok >= TOKEN_COUNT)
							tbl_shut = 1'b1;
					end
				end
			end
			default: begin
				if (r.kind == KIND_MSG_FIRST) begin
					msg_chars = '0;
					msg_done  = 1'b0;
				end
				c = r.value ^ XOR_MASK;
				if (msg_done) begin
					// Bytes after the end of a message are dropped silently.
				end else if (msg_chars >= max_len || c == TERM_CODE) begin
					msg_done = 1'b1;
					step_results.push_back(stop);
				end else if (c >= TOKEN_BASE) begin
					idx = int'(c - TOKEN_BASE);
					if (idx < TOKEN_COUNT && tok_len[idx] != 0) begin
						for (int i = 0; i < tok_len[idx] && i < MAX_TOKEN_LEN; i++) begin
							if (put_char(tok_mem[(tok_first[idx] + i) % TOKEN_STORE_BYTES][6:0]))
								break;
						end
					end
				end else begin
					void'(put_char(c[6:0]));
				end
			end
		endcase
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last = 1'b1;
		foreach (step_results[i])
			expected_results.push_back(step_results[i]);
	endfunction

	// ------------------------------------------------------------------------
	// Request driver. It offers requests from pending_reqs in bursts of random
	// length with random gaps between them. A request stays on the bus,
	// unchanged, until the block takes it, and the prediction is made at the
	// edge where it is taken.
	// ------------------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin : req_driver
		logic fire;
		logic nxt_valid;
		if (arst_n) begin
			fire      = in_valid && !in_stall;
			nxt_valid = in_valid && !fire;
			if (fire) begin
				expand_request(in_data);
				reqs_done++;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					in_data   <= pending_reqs.pop_front();
					nxt_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// Long bursts give stretches with no idling at all.
						burst_left = ($urandom_range(0, 3) == 0) ?
							$urandom_range(50, 150) : $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver stall. It switches between stall patterns every so often. Once
	// in the run, when results are waiting and plenty of requests are still to
	// come, it holds the output off for a long stretch so that the block fills
	// up and has to stall its own input.
	// ------------------------------------------------------------------------
	rx_mode_e rx_mode   = RX_FREE;
	int       mode_left = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;

	always @(posedge clk) begin : result_stall
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && out_valid && pending_reqs.size() >= 20) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_e'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_FREE:     out_stall <= 1'b0;
					RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
					RX_PERIODIC: out_stall <= (mode_left % 4 != 0);
					default:     out_stall <= 1'b0;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: every result taken is matched against the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected: code=%02h char=%b end=%b last=%b",
					results_seen, out_data.char_code, out_data.is_char,
					out_data.message_end, out_data.last));
			end else begin
				want = expected_results.pop_front();
				if (out_data.char_code !== want.char_code || out_data.is_char !== want.is_char ||
						out_data.message_end !== want.message_end ||
						out_data.last !== want.last)
					report_mismatch($sformatf(
						"result %0d: got code=%02h char=%b end=%b last=%b, want code=%02h char=%b end=%b last=%b",
						results_seen, out_data.char_code, out_data.is_char,
						out_data.message_end, out_data.last, want.char_code,
						want.is_char, want.message_end, want.last));
			end
		end
	end

	// Watchdog: gives up when neither channel has moved for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("** token_text_expander: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic queue_req(input logic [1:0] kind, input logic [7:0] value);
		in_t r;
		r.kind  = kind;
		r.value = value;
		pending_reqs.push_back(r);
		reqs_pushed++;
	endtask

	// Waits until every request has been taken and every result has come, then
	// gives a request that causes no result time to finish inside the block.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (reqs_done != reqs_pushed || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_length(input logic [CHR_W-1:0] limit);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= limit;
		@(posedge clk);
		cfg_we  <= 1'b0;
		max_len = limit;
	endtask

	// Queues a table reset, the skipped lead byte and a set of tokens. Inner
	// token bytes are non-zero with bit 7 clear; the last byte has bit 7 set.
	task automatic load_table(input tbl_shape_e shape);
		int ntok;
		int len;
		queue_req(KIND_TBL_RST, 8'($urandom));
		queue_req(KIND_TBL_BYTE, 8'($urandom));
		case (shape)
			TBL_COUNT_FULL: ntok = TOKEN_COUNT;
			TBL_STORE_FULL: ntok = TOKEN_STORE_BYTES / MAX_TOKEN_LEN;
			TBL_PLAIN:      ntok = $urandom_range(1, 16);
			default:        ntok = $urandom_range(0, 8);
		endcase
		for (int k = 0; k < ntok; k++) begin
			if (shape == TBL_COUNT_FULL)
				len = 1;
			else if (shape == TBL_STORE_FULL)
				len = MAX_TOKEN_LEN;
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(7, MAX_TOKEN_LEN);
			else
				len = $urandom_range(1, 6);
			repeat (len - 1)
				queue_req(KIND_TBL_BYTE, 8'($urandom_range(1, 127)));
			queue_req(KIND_TBL_BYTE, 8'($urandom_range(128, 255)));
		end
		table_tokens = ntok;
		case (shape)
			TBL_OVERLONG: begin
				// The byte after a full-length unfinished token closes the table.
				repeat (MAX_TOKEN_LEN + 1)
					queue_req(KIND_TBL_BYTE, 8'($urandom_range(1, 127)));
				queue_req(KIND_TBL_BYTE, 8'($urandom_range(128, 255)));
			end
			TBL_UNFINISHED: begin
				repeat ($urandom_range(1, 5))
					queue_req(KIND_TBL_BYTE, 8'($urandom_range(1, 127)));
				queue_req(KIND_TBL_BYTE, 8'h00);
				queue_req(KIND_TBL_BYTE, 8'($urandom_range(128, 255)));
			end
			TBL_PLAIN: begin
				if ($urandom_range(0, 1) == 0)
					queue_req(KIND_TBL_BYTE, 8'h00);
			end
			default: begin
				// The table is already shut or the store is full: this is dropped.
				queue_req(KIND_TBL_BYTE, 8'($urandom_range(1, 255)));
			end
		endcase
	endtask

	// One obfuscated message byte: mostly plain characters and defined tokens,
	// with terminators and arbitrary bytes mixed in.
	function automatic logic [7:0] pick_msg_byte();
		logic [7:0] c;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 55)
			c = 8'($urandom_range(0, 127));
		else if (r < 60)
			c = TERM_CODE;
		else if (r < 90 && table_tokens > 0)
			c = TOKEN_BASE + 8'($urandom_range(0, table_tokens - 1));
		else
			c = 8'($urandom_range(0, 255));
		return c ^ XOR_MASK;
	endfunction

	task automatic send_message(input int nbytes);
		queue_req(KIND_MSG_FIRST, pick_msg_byte());
		repeat (nbytes - 1) begin
			if ($urandom_range(0, 19) == 0)
				queue_req(2'($urandom_range(0, 3)), 8'($urandom));
			else
				queue_req(KIND_MSG_NEXT, pick_msg_byte());
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int         first_random;
		int         loads;
		tbl_shape_e shape;

		foreach (tok_len[i])
			tok_len[i] = '0;
		fill_pos  = '0;
		fill_tok  = '0;
		fill_run  = '0;
		skip_next = 1'b1;
		tbl_shut  = 1'b1;
		msg_chars = '0;
		msg_done  = 1'b1;
		max_len   = MAX_LENGTH_RESET;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// After power-up the table is shut and no message is open, so the
		// first two requests are dropped. The third opens a message with an
		// undefined token.
		queue_req(KIND_TBL_BYTE, 8'h41);
		queue_req(KIND_MSG_NEXT, 8'h00);
		queue_req(KIND_MSG_FIRST, (TOKEN_BASE + 8'd5) ^ XOR_MASK);
		// A small table: "Hi", a lone 0x7F and a token ending in a zero
		// character, closed by a zero byte and followed by a dropped byte.
		queue_req(KIND_TBL_RST, 8'hFF);
		queue_req(KIND_TBL_BYTE, 8'h00);
		queue_req(KIND_TBL_BYTE, 8'h48);
		queue_req(KIND_TBL_BYTE, 8'hE9);
		queue_req(KIND_TBL_BYTE, 8'hFF);
		queue_req(KIND_TBL_BYTE, 8'h01);
		queue_req(KIND_TBL_BYTE, 8'h80);
		queue_req(KIND_TBL_BYTE, 8'h00);
		queue_req(KIND_TBL_BYTE, 8'h55);
		table_tokens = 3;
		// A message with tokens, an undefined token, the extreme characters and
		// a terminator, then a byte after the end.
		queue_req(KIND_MSG_FIRST, 8'h41 ^ XOR_MASK);
		queue_req(KIND_MSG_NEXT, TOKEN_BASE ^ XOR_MASK);
		queue_req(KIND_MSG_NEXT, (TOKEN_BASE + 8'd2) ^ XOR_MASK);
		queue_req(KIND_MSG_NEXT, 8'hFF ^ XOR_MASK);
		queue_req(KIND_MSG_NEXT, 8'h00 ^ XOR_MASK);
		queue_req(KIND_MSG_NEXT, 8'h7F ^ XOR_MASK);
		queue_req(KIND_MSG_NEXT, TERM_CODE ^ XOR_MASK);
		queue_req(KIND_MSG_NEXT, 8'h12 ^ XOR_MASK);
		// This message stays open across the register write below, so its
		// next byte finds the limit already passed.
		queue_req(KIND_MSG_FIRST, (TOKEN_BASE + 8'd1) ^ XOR_MASK);
		set_max_length(10'd1);
		queue_req(KIND_MSG_NEXT, 8'h42 ^ XOR_MASK);
		queue_req(KIND_MSG_FIRST, 8'h78 ^ XOR_MASK);
		queue_req(KIND_MSG_NEXT, 8'h79 ^ XOR_MASK);
		// With a limit of zero a message ends before its first character.
		set_max_length(10'd0);
		queue_req(KIND_MSG_FIRST, 8'h7A ^ XOR_MASK);

		// Random phases: a new limit each time, now and then a new table, and
		// a few messages. The first loads go through each shape but TBL_STORE_FULL.
		first_random = reqs_pushed;
		loads        = 0;
		while (reqs_pushed - first_random < RANDOM_REQS) begin
			case ($urandom_range(0, 5))
				0:       set_max_length(10'd1);
				1:       set_max_length(10'($urandom_range(2, 12)));
				2:       set_max_length(MAX_LENGTH_RESET);
				3:       set_max_length(10'd1023);
				default: set_max_length(10'($urandom_range(1, 1023)));
			endcase
			if (loads < 4 || $urandom_range(0, 2) == 0) begin
				if (loads < 4)
					shape = tbl_shape_e'(loads);
				else if ($urandom_range(0, 9) == 0)
					shape = TBL_COUNT_FULL;
				else
					shape = tbl_shape_e'($urandom_range(0, 2));
				load_table(shape);
				loads++;
			end
			repeat ($urandom_range(1, 4))
				send_message($urandom_range(2, 24));
		end

		// A few closing messages at the reset limit.
		set_max_length(MAX_LENGTH_RESET);
		repeat (3)
			send_message($urandom_range(8, 24));

		wait_idle();
		if (mismatches == 0)
			$display("** token_text_expander: PASSED **");
		else
			$display("** token_text_expander: FAILED **");
		$finish;
	end

endmodule
